// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/scm_pkg.sv -----
// ---------------------------------------------------------------------------
// scm_pkg
// types, constants and command codes of the sphere collision merge block
// ---------------------------------------------------------------------------
package scm_pkg;

    localparam int MAX_PARTICLES = 64;
    localparam int IDX_W         = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
    localparam int WORD_W        = 32;
    localparam int MUL_W         = WORD_W + 1;
    localparam int PROD_W        = 2 * MUL_W;
    localparam int CUBE_W        = 3 * WORD_W;
    localparam int ACC_W         = CUBE_W + 1;
    localparam int DIVIDEND_W    = 2 * WORD_W + 1;
    localparam int DIVISOR_W     = WORD_W + 1;
    localparam int BIT_W         = $clog2(WORD_W);

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
    localparam logic [OP_W-1:0] OP_DX     = 4'd1;
    localparam logic [OP_W-1:0] OP_DY     = 4'd2;
    localparam logic [OP_W-1:0] OP_DZ     = 4'd3;
    localparam logic [OP_W-1:0] OP_DR     = 4'd4;
    localparam logic [OP_W-1:0] OP_VA     = 4'd5;
    localparam logic [OP_W-1:0] OP_VB     = 4'd6;
    localparam logic [OP_W-1:0] OP_VC     = 4'd7;
    localparam logic [OP_W-1:0] OP_VW     = 4'd8;
    localparam logic [OP_W-1:0] OP_CB_SET = 4'd9;
    localparam logic [OP_W-1:0] OP_Q0     = 4'd10;
    localparam logic [OP_W-1:0] OP_Q1     = 4'd11;
    localparam logic [OP_W-1:0] OP_Q2     = 4'd12;
    localparam logic [OP_W-1:0] OP_Q3     = 4'd13;
    localparam logic [OP_W-1:0] OP_FIN    = 4'd14;

    localparam logic [1:0] CTX_R1   = 2'd0;
    localparam logic [1:0] CTX_R2   = 2'd1;
    localparam logic [1:0] CTX_ROOT = 2'd2;

    typedef struct packed {
        logic [2:0][WORD_W-1:0] pos;
        logic [2:0][WORD_W-1:0] vel;
        logic [WORD_W-1:0]      mass;
        logic [WORD_W-1:0]      radius;
    } body_t;

    typedef struct packed {
        logic             load_wr;
        logic             wb_wr;
        logic [IDX_W-1:0] wr_addr;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             cur_load;
        logic             out_load;
        logic [OP_W-1:0]  op;
        logic [1:0]       k;
        logic [1:0]       ctx;
        logic [BIT_W-1:0] bit_idx;
    } scm_cmd_t;

    typedef struct packed {
        logic overlap;
        logic total_zero;
        logic div_busy;
    } scm_sts_t;

endpackage

// ----- rtl/sphere_collision_merge_top.sv -----
// ---------------------------------------------------------------------------
// sphere_collision_merge_top
// inelastic merge of overlapping spheres in Q16.16, up to 64 particles
// ---------------------------------------------------------------------------
// usage:
//   input channel: an item is taken on a rising edge with start high and
//   busy low. while idle one particle loads per cycle into the store; an
//   item that finds the store full is dropped. an item with is_last set
//   starts the merge pass and busy stays high until all survivors are out.
//   result channel: each survivor is shown for one cycle with out_valid
//   high, in index order; out_last marks the final one. results cannot be
//   held off, nothing waits on the receiver.
//   merge steps: the divider runs once per velocity component and the
//   cube root takes 32 steps, each step using the shared 33x33
//   multiplier three times.
//   reset: asynchronous, active low; clears the live mask, the load count
//   and the sequencer. store contents are not cleared.
// ---------------------------------------------------------------------------
module sphere_collision_merge_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic [31:0]        mass_in,
    input  logic [31:0]        radius_in,
    input  logic               is_last,
    output logic               out_valid,
    output logic signed [31:0] out_pos_x,
    output logic signed [31:0] out_pos_y,
    output logic signed [31:0] out_pos_z,
    output logic signed [31:0] out_vel_x,
    output logic signed [31:0] out_vel_y,
    output logic signed [31:0] out_vel_z,
    output logic [31:0]        out_mass,
    output logic [31:0]        out_radius,
    output logic               out_last
);
    import scm_pkg::*;

    scm_cmd_t cmd;
    scm_sts_t sts;

    scm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .is_last   (is_last),
        .busy      (busy),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_last  (out_last)
    );

    scm_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .vel_z      (vel_z),
        .mass_in    (mass_in),
        .radius_in  (radius_in),
        .out_pos_x  (out_pos_x),
        .out_pos_y  (out_pos_y),
        .out_pos_z  (out_pos_z),
        .out_vel_x  (out_vel_x),
        .out_vel_y  (out_vel_y),
        .out_vel_z  (out_vel_z),
        .out_mass   (out_mass),
        .out_radius (out_radius)
    );

endmodule

// ----- rtl/scm_div.sv -----
// ---------------------------------------------------------------------------
// scm_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module scm_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [scm_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [scm_pkg::DIVISOR_W-1:0]  divisor,
    output logic                           busy,
    output logic [scm_pkg::DIVIDEND_W-1:0] quotient
);
    import scm_pkg::*;

    localparam int DCNT_W = $clog2(DIVIDEND_W + 1);

    logic [DCNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] q_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  d_reg;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    assign busy     = (cnt_reg != '0);
    assign quotient = q_reg;
    assign trial    = {rem_reg, q_reg[DIVIDEND_W-1]};
    assign ge       = (trial >= {1'b0, d_reg});
    assign diff     = trial - {1'b0, d_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        if (start)
            cnt_next = DCNT_W'(DIVIDEND_W);
        else if (busy)
            cnt_next = cnt_reg - DCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy)
        begin
            rem_reg <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            q_reg   <= {q_reg[DIVIDEND_W-2:0], ge};
        end
    end

endmodule

// ----- rtl/scm_datapath.sv -----
// ---------------------------------------------------------------------------
// scm_datapath
// particle store, working particle, shared multiplier, divider and root
// ---------------------------------------------------------------------------
module scm_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  scm_pkg::scm_cmd_t          cmd,
    output scm_pkg::scm_sts_t          sts,
    input  logic signed [31:0]         pos_x,
    input  logic signed [31:0]         pos_y,
    input  logic signed [31:0]         pos_z,
    input  logic signed [31:0]         vel_x,
    input  logic signed [31:0]         vel_y,
    input  logic signed [31:0]         vel_z,
    input  logic [31:0]                mass_in,
    input  logic [31:0]                radius_in,
    output logic signed [31:0]         out_pos_x,
    output logic signed [31:0]         out_pos_y,
    output logic signed [31:0]         out_pos_z,
    output logic signed [31:0]         out_vel_x,
    output logic signed [31:0]         out_vel_y,
    output logic signed [31:0]         out_vel_z,
    output logic [31:0]                out_mass,
    output logic [31:0]                out_radius
);
    import scm_pkg::*;

    function automatic logic [WORD_W-1:0] mag33(input logic [WORD_W:0] d);
        logic [WORD_W:0] t;
        t = d[WORD_W] ? (~d + (WORD_W+1)'(1)) : d;
        return t[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] v);
        return v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
    endfunction

    body_t mem [MAX_PARTICLES];
    body_t rd_reg;
    body_t cur_reg;
    body_t out_reg;
    body_t in_body;

    logic [PROD_W-1:0]     prod_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic [2*WORD_W-1:0]   a_reg;
    logic                  neg_reg;
    logic [WORD_W-1:0]     cb_reg;
    logic [WORD_W-1:0]     sqhi_reg;
    logic [2*WORD_W-1:0]   cl_reg;
    logic [WORD_W-1:0]     root_reg;

    logic [MUL_W-1:0]      mul_a, mul_b;
    logic [PROD_W-1:0]     mul_p;
    logic                  mul_en;
    logic [2:0][WORD_W-1:0] dabs;
    logic [WORD_W:0]       rsum;
    logic [WORD_W:0]       total;
    logic [CUBE_W-1:0]     cube;
    logic [2*WORD_W-1:0]   b_prod;
    logic                  na, nb, neg;
    logic [DIVIDEND_W-1:0] mag;
    logic [DIVIDEND_W-1:0] quot;
    logic [WORD_W-1:0]     qsat, vnew;
    logic                  div_busy;
    logic                  div_start;

    assign in_body.pos    = {pos_z, pos_y, pos_x};
    assign in_body.vel    = {vel_z, vel_y, vel_x};
    assign in_body.mass   = mass_in;
    assign in_body.radius = radius_in;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            dabs[c] = mag33({cur_reg.pos[c][WORD_W-1], cur_reg.pos[c]}
                            - {rd_reg.pos[c][WORD_W-1], rd_reg.pos[c]});
    end

    assign rsum  = {1'b0, cur_reg.radius} + {1'b0, rd_reg.radius};
    assign total = {1'b0, cur_reg.mass} + {1'b0, rd_reg.mass};
    assign cube  = {{WORD_W{1'b0}}, cl_reg} + {prod_reg[2*WORD_W-1:0], {WORD_W{1'b0}}};

    // operand select for the shared multiplier
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (cmd.op)
            OP_DX:
            begin
                mul_a = {1'b0, dabs[0]};
                mul_b = {1'b0, dabs[0]};
            end
            OP_DY:
            begin
                mul_a = {1'b0, dabs[1]};
                mul_b = {1'b0, dabs[1]};
            end
            OP_DZ:
            begin
                mul_a = {1'b0, dabs[2]};
                mul_b = {1'b0, dabs[2]};
            end
            OP_DR:
            begin
                mul_a = rsum;
                mul_b = rsum;
            end
            OP_VA:
            begin
                mul_a = {1'b0, mag32(cur_reg.vel[cmd.k])};
                mul_b = {1'b0, cur_reg.mass};
            end
            OP_VB:
            begin
                mul_a = {1'b0, mag32(rd_reg.vel[cmd.k])};
                mul_b = {1'b0, rd_reg.mass};
            end
            OP_Q0:
            begin
                mul_a = {1'b0, cb_reg};
                mul_b = {1'b0, cb_reg};
            end
            OP_Q1:
            begin
                mul_a = {1'b0, prod_reg[WORD_W-1:0]};
                mul_b = {1'b0, cb_reg};
            end
            OP_Q2:
            begin
                mul_a = {1'b0, sqhi_reg};
                mul_b = {1'b0, cb_reg};
            end
            default:
                mul_en = 1'b0;
        endcase
    end

    // full-width product of the 33-bit operands
    assign mul_p = mul_a * mul_b;

    // signed sum of the two momentum terms
    assign b_prod = prod_reg[2*WORD_W-1:0];
    assign na     = cur_reg.vel[cmd.k][WORD_W-1];
    assign nb     = rd_reg.vel[cmd.k][WORD_W-1];

    always_comb
    begin
        priority if (na == nb)
        begin
            mag = {1'b0, a_reg} + {1'b0, b_prod};
            neg = na;
        end
        else if (a_reg >= b_prod)
        begin
            mag = {1'b0, a_reg - b_prod};
            neg = na;
        end
        else
        begin
            mag = {1'b0, b_prod - a_reg};
            neg = nb;
        end
    end

    assign div_start = (cmd.op == OP_VC);

    scm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag),
        .divisor  (total),
        .busy     (div_busy),
        .quotient (quot)
    );

    // saturate the quotient to the signed word range
    always_comb
    begin
        if (neg_reg)
        begin
            qsat = (quot > DIVIDEND_W'(64'h8000_0000)) ? 32'h8000_0000 : quot[WORD_W-1:0];
            vnew = ~qsat + WORD_W'(1);
        end
        else
        begin
            qsat = (quot > DIVIDEND_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quot[WORD_W-1:0];
            vnew = qsat;
        end
    end

    assign sts.overlap    = (acc_reg < ACC_W'(prod_reg));
    assign sts.total_zero = (total == '0);
    assign sts.div_busy   = div_busy;

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
            mem[cmd.wr_addr] <= in_body;
        else if (cmd.wb_wr)
            mem[cmd.wr_addr] <= cur_reg;
        if (cmd.rd_en)
            rd_reg <= mem[cmd.rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= mul_p;
        if (cmd.cur_load)
            cur_reg <= rd_reg;
        if (cmd.out_load)
            out_reg <= rd_reg;
        unique case (cmd.op)
            OP_DY:
                acc_reg <= ACC_W'(prod_reg);
            OP_DZ, OP_DR:
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            OP_VB:
                a_reg <= prod_reg[2*WORD_W-1:0];
            OP_VC:
                neg_reg <= neg;
            OP_VW:
                cur_reg.vel[cmd.k] <= vnew;
            OP_CB_SET:
            begin
                unique case (cmd.ctx)
                    CTX_R1:   cb_reg <= cur_reg.radius;
                    CTX_R2:   cb_reg <= rd_reg.radius;
                    default:  cb_reg <= root_reg | (WORD_W'(1) << cmd.bit_idx);
                endcase
            end
            OP_Q1:
                sqhi_reg <= prod_reg[2*WORD_W-1:WORD_W];
            OP_Q2:
                cl_reg <= prod_reg[2*WORD_W-1:0];
            OP_Q3:
            begin
                unique case (cmd.ctx)
                    CTX_R1:
                        acc_reg <= ACC_W'(cube);
                    CTX_R2:
                    begin
                        acc_reg  <= acc_reg + ACC_W'(cube);
                        root_reg <= '0;
                    end
                    default:
                        if (!(acc_reg < ACC_W'(cube)))
                            root_reg <= cb_reg;
                endcase
            end
            OP_FIN:
            begin
                cur_reg.radius <= root_reg;
                cur_reg.mass   <= total[WORD_W] ? '1 : total[WORD_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign out_pos_x  = out_reg.pos[0];
    assign out_pos_y  = out_reg.pos[1];
    assign out_pos_z  = out_reg.pos[2];
    assign out_vel_x  = out_reg.vel[0];
    assign out_vel_y  = out_reg.vel[1];
    assign out_vel_z  = out_reg.vel[2];
    assign out_mass   = out_reg.mass;
    assign out_radius = out_reg.radius;

endmodule

// ----- rtl/scm_ctrl.sv -----
// ---------------------------------------------------------------------------
// scm_ctrl
// sequencer: loading, pair walk, merge steps and survivor output
// ---------------------------------------------------------------------------
module scm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               is_last,
    output logic               busy,
    output scm_pkg::scm_cmd_t  cmd,
    input  scm_pkg::scm_sts_t  sts,
    output logic               out_valid,
    output logic               out_last
);
    import scm_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_I_START = 5'd1;
    localparam logic [4:0] S_I_LOAD  = 5'd2;
    localparam logic [4:0] S_J_START = 5'd3;
    localparam logic [4:0] S_DX      = 5'd4;
    localparam logic [4:0] S_DY      = 5'd5;
    localparam logic [4:0] S_DZ      = 5'd6;
    localparam logic [4:0] S_DR      = 5'd7;
    localparam logic [4:0] S_DCMP    = 5'd8;
    localparam logic [4:0] S_VA      = 5'd9;
    localparam logic [4:0] S_VB      = 5'd10;
    localparam logic [4:0] S_VC      = 5'd11;
    localparam logic [4:0] S_VW      = 5'd12;
    localparam logic [4:0] S_CB_SET  = 5'd13;
    localparam logic [4:0] S_Q0      = 5'd14;
    localparam logic [4:0] S_Q1      = 5'd15;
    localparam logic [4:0] S_Q2      = 5'd16;
    localparam logic [4:0] S_Q3      = 5'd17;
    localparam logic [4:0] S_FIN     = 5'd18;
    localparam logic [4:0] S_O_START = 5'd19;
    localparam logic [4:0] S_O_EMIT  = 5'd20;

    logic [4:0]               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         i_reg, i_next;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic [1:0]               k_reg, k_next;
    logic [1:0]               ctx_reg, ctx_next;
    logic [BIT_W-1:0]         bit_reg, bit_next;
    logic [MAX_PARTICLES-1:0] alive_reg, alive_next;
    logic                     valid_reg, valid_next;
    logic                     last_reg, last_next;
    logic [MAX_PARTICLES-1:0] upper;
    logic                     full;

    assign busy      = (state_reg != S_IDLE);
    assign out_valid = valid_reg;
    assign out_last  = last_reg;
    assign full      = (cnt_reg >= CNT_W'(MAX_PARTICLES));
    assign upper     = alive_reg >> i_reg[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        ctx_next   = ctx_reg;
        bit_next   = bit_reg;
        alive_next = alive_reg;
        valid_next = 1'b0;
        last_next  = last_reg;

        cmd         = '0;
        cmd.k       = k_reg;
        cmd.ctx     = ctx_reg;
        cmd.bit_idx = bit_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (!full)
                    begin
                        cmd.load_wr = 1'b1;
                        cmd.wr_addr = cnt_reg[IDX_W-1:0];
                        alive_next[cnt_reg[IDX_W-1:0]] = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (is_last)
                    begin
                        i_next     = '0;
                        state_next = S_I_START;
                    end
                end
            end
            S_I_START:
            begin
                priority if (i_reg >= cnt_reg)
                begin
                    i_next     = '0;
                    state_next = S_O_START;
                end
                else if (!alive_reg[i_reg[IDX_W-1:0]])
                    i_next = i_reg + CNT_W'(1);
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = i_reg[IDX_W-1:0];
                    state_next  = S_I_LOAD;
                end
            end
            S_I_LOAD:
            begin
                cmd.cur_load = 1'b1;
                j_next       = i_reg + CNT_W'(1);
                state_next   = S_J_START;
            end
            S_J_START:
            begin
                priority if (j_reg >= cnt_reg)
                begin
                    cmd.wb_wr   = 1'b1;
                    cmd.wr_addr = i_reg[IDX_W-1:0];
                    i_next      = i_reg + CNT_W'(1);
                    state_next  = S_I_START;
                end
                else if (!alive_reg[j_reg[IDX_W-1:0]])
                    j_next = j_reg + CNT_W'(1);
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = j_reg[IDX_W-1:0];
                    state_next  = S_DX;
                end
            end
            S_DX:
            begin
                cmd.op     = OP_DX;
                state_next = S_DY;
            end
            S_DY:
            begin
                cmd.op     = OP_DY;
                state_next = S_DZ;
            end
            S_DZ:
            begin
                cmd.op     = OP_DZ;
                state_next = S_DR;
            end
            S_DR:
            begin
                cmd.op     = OP_DR;
                state_next = S_DCMP;
            end
            S_DCMP:
            begin
                priority if (!sts.overlap)
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_J_START;
                end
                else if (sts.total_zero)
                begin
                    // zero total mass keeps the velocity
                    ctx_next   = CTX_R1;
                    state_next = S_CB_SET;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_VA;
                end
            end
            S_VA:
            begin
                cmd.op     = OP_VA;
                state_next = S_VB;
            end
            S_VB:
            begin
                cmd.op     = OP_VB;
                state_next = S_VC;
            end
            S_VC:
            begin
                cmd.op     = OP_VC;
                state_next = S_VW;
            end
            S_VW:
            begin
                if (!sts.div_busy)
                begin
                    cmd.op = OP_VW;
                    if (k_reg == 2'd2)
                    begin
                        ctx_next   = CTX_R1;
                        state_next = S_CB_SET;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = S_VA;
                    end
                end
            end
            S_CB_SET:
            begin
                cmd.op     = OP_CB_SET;
                state_next = S_Q0;
            end
            S_Q0:
            begin
                cmd.op     = OP_Q0;
                state_next = S_Q1;
            end
            S_Q1:
            begin
                cmd.op     = OP_Q1;
                state_next = S_Q2;
            end
            S_Q2:
            begin
                cmd.op     = OP_Q2;
                state_next = S_Q3;
            end
            S_Q3:
            begin
                cmd.op = OP_Q3;
                unique case (ctx_reg)
                    CTX_R1:
                    begin
                        ctx_next   = CTX_R2;
                        state_next = S_CB_SET;
                    end
                    CTX_R2:
                    begin
                        ctx_next   = CTX_ROOT;
                        bit_next   = '1;
                        state_next = S_CB_SET;
                    end
                    default:
                    begin
                        if (bit_reg == '0)
                            state_next = S_FIN;
                        else
                        begin
                            bit_next   = bit_reg - BIT_W'(1);
                            state_next = S_CB_SET;
                        end
                    end
                endcase
            end
            S_FIN:
            begin
                cmd.op = OP_FIN;
                alive_next[j_reg[IDX_W-1:0]] = 1'b0;
                j_next     = j_reg + CNT_W'(1);
                state_next = S_J_START;
            end
            S_O_START:
            begin
                priority if (i_reg >= cnt_reg)
                begin
                    alive_next = '0;
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else if (!alive_reg[i_reg[IDX_W-1:0]])
                    i_next = i_reg + CNT_W'(1);
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = i_reg[IDX_W-1:0];
                    state_next  = S_O_EMIT;
                end
            end
            S_O_EMIT:
            begin
                cmd.out_load = 1'b1;
                valid_next   = 1'b1;
                last_next    = !(|upper[MAX_PARTICLES-1:1]);
                i_next       = i_reg + CNT_W'(1);
                state_next   = S_O_START;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            ctx_reg   <= CTX_R1;
            bit_reg   <= '0;
            alive_reg <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            ctx_reg   <= ctx_next;
            bit_reg   <= bit_next;
            alive_reg <= alive_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

endmodule

// ----- rtl/scm_checker.sv -----
// ---------------------------------------------------------------------------
// scm_checker
// port-level checks on the sphere collision merge block
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module scm_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic is_last,
    input logic out_valid,
    input logic out_last
);

    // results only come out during a pass
    `ASSERT_IMPL(a_out_in_pass, clk, rst_n, out_valid, busy)
    // nothing follows the final survivor right away
    `ASSERT_NEXT(a_last_alone, clk, rst_n, out_valid && out_last, !out_valid)
    // a last item always starts a pass
    `ASSERT_NEXT(a_last_starts, clk, rst_n, start && !busy && is_last, busy)
    // a pass only starts on a last item
    `ASSERT_IMPL(a_busy_cause, clk, rst_n, $rose(busy), $past(start && is_last))

endmodule

bind sphere_collision_merge_top scm_checker u_scm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .is_last   (is_last),
    .out_valid (out_valid),
    .out_last  (out_last)
);

// ----- sim/sphere_collision_merge_top_tb.sv -----
// ---------------------------------------------------------------------------
// sphere_collision_merge_top_tb
// self-checking bench for the sphere collision merge block
// ---------------------------------------------------------------------------
// particle sets go through the input channel. A merge predictor runs on every
// accepted item and queues the expected survivors. The monitor compares each
// strobed result with the oldest expected survivor, one field at a time.
// The run starts with directed sets: touching spheres, zero and saturating
// mass, extreme positions and radii, chain merges and an overfull store.
// After that come random clustered and noise sets.
// ---------------------------------------------------------------------------
module sphere_collision_merge_top_tb;

    import scm_pkg::*;

    typedef struct {
        logic signed [31:0] px, py, pz, vx, vy, vz;
        logic [31:0]        m, r;
        logic               last;
    } particle_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
    logic [31:0] mass_in = '0, radius_in = '0;
    logic is_last = 1'b0;
    logic out_valid;
    logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
    logic signed [31:0] out_vel_x, out_vel_y, out_vel_z;
    logic [31:0] out_mass, out_radius;
    logic out_last;

    particle_t pending_items[$];
    particle_t expected_survivors[$];
    particle_t body_store[MAX_PARTICLES];
    logic [MAX_PARTICLES-1:0] live_mask = '0;
    int  bodies_loaded = 0;
    int  items_taken = 0;
    int  items_sent = 0;
    int  items_total = 0;
    int  fail_count = 0;

    sphere_collision_merge_top u_top (.*);

    always #5 clk = ~clk;

    function automatic logic [127:0] cube3(logic [31:0] c);
        return 128'(c) * 128'(c) * 128'(c);
    endfunction

    function automatic logic [127:0] sq_dist(logic signed [31:0] a, logic signed [31:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0) d = -d;
        return 128'(d) * 128'(d);
    endfunction

    function automatic bit spheres_overlap(particle_t a, particle_t b);
        logic [127:0] sep2, rs;
        sep2 = sq_dist(a.px, b.px) + sq_dist(a.py, b.py) + sq_dist(a.pz, b.pz);
        rs = 128'(a.r) + 128'(b.r);
        return sep2 < rs * rs;
    endfunction

    function automatic logic signed [31:0] weighted_vel(logic signed [31:0] v1,
            logic [31:0] m1, logic signed [31:0] v2, logic [31:0] m2,
            logic [32:0] total);
        longint l1, l2;
        logic [127:0] a, b, mag, q;
        bit neg;
        l1 = v1;
        l2 = v2;
        a = 128'(l1 < 0 ? -l1 : l1) * 128'(m1);
        b = 128'(l2 < 0 ? -l2 : l2) * 128'(m2);
        if ((l1 < 0) == (l2 < 0)) begin
            mag = a + b;
            neg = l1 < 0;
        end else if (a >= b) begin
            mag = a - b;
            neg = l1 < 0;
        end else begin
            mag = b - a;
            neg = l2 < 0;
        end
        q = mag / 128'(total);
        if (neg) begin
            if (q > 128'h8000_0000) q = 128'h8000_0000;
            return -q[31:0];
        end
        if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic logic [31:0] cube_root(logic [127:0] s);
        logic [31:0] c, t;
        c = '0;
        for (int b = 31; b >= 0; b--) begin
            t = c | (32'd1 << b);
            if (!(s < cube3(t))) c = t;
        end
        return c;
    endfunction

    // absorb j into i: i keeps its position
    function automatic void absorb(int i, int j);
        logic [32:0] total;
        particle_t a, b;
        a = body_store[i];
        b = body_store[j];
        total = 33'(a.m) + 33'(b.m);
        if (total != 0) begin
            a.vx = weighted_vel(a.vx, a.m, b.vx, b.m, total);
            a.vy = weighted_vel(a.vy, a.m, b.vy, b.m, total);
            a.vz = weighted_vel(a.vz, a.m, b.vz, b.m, total);
        end
        a.m = total[32] ? 32'hFFFF_FFFF : total[31:0];
        a.r = cube_root(cube3(body_store[i].r) + cube3(b.r));
        body_store[i] = a;
    endfunction

    function automatic void predict_merge(particle_t it);
        int last_idx;
        particle_t res;
        if (bodies_loaded < MAX_PARTICLES) begin
            body_store[bodies_loaded] = it;
            live_mask[bodies_loaded] = 1'b1;
            bodies_loaded++;
        end
        if (!it.last) return;
        for (int i = 0; i < bodies_loaded; i++) begin
            if (!live_mask[i]) continue;
            for (int j = i + 1; j < bodies_loaded; j++) begin
                if (live_mask[j] && spheres_overlap(body_store[i], body_store[j])) begin
                    absorb(i, j);
                    live_mask[j] = 1'b0;
                end
            end
        end
        last_idx = -1;
        for (int i = 0; i < bodies_loaded; i++)
            if (live_mask[i]) last_idx = i;
        for (int i = 0; i < bodies_loaded; i++) begin
            if (!live_mask[i]) continue;
            res = body_store[i];
            res.last = (i == last_idx);
            expected_survivors.push_back(res);
        end
        live_mask = '0;
        bodies_loaded = 0;
    endfunction

    // accept and predict
    always @(posedge clk) begin
        particle_t it;
        if (rst_n && start && !busy) begin
            it = '{pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, mass_in, radius_in, is_last};
            predict_merge(it);
            items_taken++;
        end
    end

    // driver: a new item goes out once the previous one has been taken
    always @(negedge clk) begin
        particle_t it;
        int idle_pct;
        if (rst_n && (!start || items_taken == items_sent)) begin
            idle_pct = (items_taken < items_total / 3) ? 7 :
                       (items_taken < 2 * items_total / 3) ? 68 : 0;
            if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
                it = pending_items.pop_front();
                pos_x <= it.px; pos_y <= it.py; pos_z <= it.pz;
                vel_x <= it.vx; vel_y <= it.vy; vel_z <= it.vz;
                mass_in <= it.m; radius_in <= it.r; is_last <= it.last;
                start <= 1'b1;
                items_sent++;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        particle_t e;
        if (rst_n && out_valid) begin
            if (expected_survivors.size() == 0) begin
                $error("unexpected survivor item");
                fail_count++;
            end else begin
                e = expected_survivors.pop_front();
                if (out_pos_x !== e.px) begin
                    $error("out_pos_x exp %h got %h", e.px, out_pos_x); fail_count++;
                end
                if (out_pos_y !== e.py) begin
                    $error("out_pos_y exp %h got %h", e.py, out_pos_y); fail_count++;
                end
                if (out_pos_z !== e.pz) begin
                    $error("out_pos_z exp %h got %h", e.pz, out_pos_z); fail_count++;
                end
                if (out_vel_x !== e.vx) begin
                    $error("out_vel_x exp %h got %h", e.vx, out_vel_x); fail_count++;
                end
                if (out_vel_y !== e.vy) begin
                    $error("out_vel_y exp %h got %h", e.vy, out_vel_y); fail_count++;
                end
                if (out_vel_z !== e.vz) begin
                    $error("out_vel_z exp %h got %h", e.vz, out_vel_z); fail_count++;
                end
                if (out_mass !== e.m) begin
                    $error("out_mass exp %h got %h", e.m, out_mass); fail_count++;
                end
                if (out_radius !== e.r) begin
                    $error("out_radius exp %h got %h", e.r, out_radius); fail_count++;
                end
                if (out_last !== e.last) begin
                    $error("out_last exp %b got %b", e.last, out_last); fail_count++;
                end
            end
        end
    end

    function automatic particle_t mk(int px, int py, int pz, int vx, int vy, int vz,
            logic [31:0] m, logic [31:0] r, bit last);
        particle_t p;
        p = '{px, py, pz, vx, vy, vz, m, r, last};
        return p;
    endfunction

    function automatic particle_t random_body(int kind, bit last);
        particle_t p;
        int span;
        if (kind == 0) begin
            p = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, last};
        end else begin
            // clustered spheres so overlaps are common
            span = 1 << $urandom_range(22, 16);
            p.px = $urandom_range(2 * span) - span;
            p.py = $urandom_range(2 * span) - span;
            p.pz = $urandom_range(2 * span) - span;
            p.vx = $urandom;
            p.vy = $urandom;
            p.vz = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 20) - (1 << 19);
            p.m = ($urandom_range(7) == 0) ? $urandom :
                  ($urandom_range(7) == 0) ? 32'd0 : $urandom_range(1 << 20);
            p.r = ($urandom_range(15) == 0) ? $urandom : $urandom_range(span / 2);
            p.last = last;
        end
        return p;
    endfunction

    function automatic void add_set(int n, int kind);
        for (int k = 0; k < n; k++)
            pending_items.push_back(random_body(kind, k == n - 1));
    endfunction

    initial begin
        int n;
        // touching spheres stay apart
        pending_items.push_back(mk(0, 0, 0, 5, 6, 7, 32'h10000, 32'h10000, 0));
        pending_items.push_back(mk(32'h20000, 0, 0, 1, 2, 3, 32'h10000, 32'h10000, 1));
        // zero total mass keeps velocity
        pending_items.push_back(mk(0, 0, 0, -100, 200, 32'h7FFF_FFFF, 0, 32'h8000, 0));
        pending_items.push_back(mk(16, 0, 0, 300, -400, 32'h8000_0000, 0, 32'h8000, 1));
        // saturating mass, extreme velocities
        pending_items.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
        pending_items.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, -1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
        // single particle
        pending_items.push_back(mk(-1, -1, -1, -1, -1, -1, 32'hFFFF_FFFF, 0, 1));
        // chain: later pairs see grown radius
        pending_items.push_back(mk(0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h18000, 0));
        pending_items.push_back(mk(32'h20000, 0, 0, -32'h10000, 0, 0, 32'h30000, 32'h8000, 0));
        pending_items.push_back(mk(32'h34000, 0, 0, 0, 32'h10000, 0, 32'h10000, 32'h4000, 0));
        pending_items.push_back(mk(32'h100000, 0, 0, 0, 0, 32'h10000, 1, 1, 1));
        add_set(5, 1);
        // overfull store: the last two items are dropped, the pass still runs
        add_set(MAX_PARTICLES + 2, 1);
        while (pending_items.size() < 420) begin
            n = ($urandom_range(30) == 0) ? MAX_PARTICLES : $urandom_range(12, 1);
            add_set(n, ($urandom_range(4) == 0) ? 0 : 1);
        end
        items_total = pending_items.size();
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        wait (pending_items.size() == 0 && items_taken == items_total);
        wait (expected_survivors.size() == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0 && expected_survivors.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/scm_pkg.sv
rtl/scm_div.sv
rtl/scm_datapath.sv
rtl/scm_ctrl.sv
rtl/sphere_collision_merge_top.sv
rtl/scm_checker.sv
sim/sphere_collision_merge_top_tb.sv
